// ===== design/vdp_pkg.sv =====
`default_nettype none
package vdp_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int COORD_BITS = 16;
    localparam int IN_COORD_BITS = 16;
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int OUT_IDX_W = 8;
    localparam int VTX_W = 3 * COORD_BITS;

    // item kind codes carried in tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [VTX_W-1:0] t_vertex;

    // one-port memory request
    typedef struct packed {
        logic           we;
        logic [IDX_W-1:0] addr;
        t_vertex        wdata;
    } t_mem_req;

    // sign-extend a 16-bit coordinate, keep the low COORD_BITS bits
    function automatic t_coord norm_coord(input logic [IN_COORD_BITS-1:0] raw);
        logic [31:0] ext;
        ext = {{(32 - IN_COORD_BITS){raw[IN_COORD_BITS-1]}}, raw};
        return ext[COORD_BITS-1:0];
    endfunction

    // low 8 bits of an index or count value
    function automatic logic [OUT_IDX_W-1:0] out_index(input logic [CNT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/vdp_store.sv =====
`default_nettype none
module vdp_store (
    input  wire logic              i_clk,
    input  wire vdp_pkg::t_mem_req i_req,
    output logic [vdp_pkg::VTX_W-1:0] o_rdata
);

    logic [vdp_pkg::VTX_W-1:0] r_mem [vdp_pkg::POOL_DEPTH];

    // single port: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end else begin
            o_rdata <= r_mem[i_req.addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/vertex_dedup_pool.sv =====
// vertex_dedup_pool: one item in flight, tready high only while idle
// a result waits on the entry-by-entry scan, one memory port, one comparator: a hit ends
//   the scan at the first matching entry, a miss reads every valid entry
// a new item is taken only once the last result is in the output register; output stalls delay that
// reset: synchronous active low; pool empties (count cleared), memory content left as is
// the result waits in an output register, so the next item is taken while it is pending
`default_nettype none
module vertex_dedup_pool (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
    input  wire logic        i_s_tuser,  // kind (0 insert, 1 lookup)
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // entry_index [7:0]
    output logic [1:0]       o_m_tuser   // found [0], pool_full [1]
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [vdp_pkg::CNT_W-1:0]  r_cnt, n_cnt;       // number of valid entries
    logic [vdp_pkg::CNT_W-1:0]  r_idx, n_idx;       // next entry to read
    logic [vdp_pkg::CNT_W-1:0]  r_rd_idx, n_rd_idx; // entry whose data arrives now
    logic                       r_rd_vld, n_rd_vld; // a read is outstanding
    logic                       r_hit, n_hit;
    logic [vdp_pkg::CNT_W-1:0]  r_hit_idx, n_hit_idx;

    // captured item
    logic                       r_kind;
    vdp_pkg::t_vertex           r_vtx;

    // output register
    logic                       r_out_vld, n_out_vld;
    logic [7:0]                 r_out_idx, n_out_idx;
    logic                       r_out_found, n_out_found;
    logic                       r_out_full, n_out_full;

    vdp_pkg::t_mem_req          mem_req;
    vdp_pkg::t_vertex           mem_rdata;
    logic                       match;
    logic                       out_free;

    vdp_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_idx;
    assign o_m_tuser  = {r_out_full, r_out_found};

    // shared comparator: exact match on all three coordinates
    assign match    = r_rd_vld && (mem_rdata == r_vtx);
    assign out_free = !r_out_vld || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = 1'b0;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_out_vld   = r_out_vld && !i_m_tready;
        n_out_idx   = r_out_idx;
        n_out_found = r_out_found;
        n_out_full  = r_out_full;
        mem_req.we    = 1'b0;
        mem_req.addr  = r_idx[vdp_pkg::IDX_W-1:0];
        mem_req.wdata = r_vtx;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    // first match ends the scan
                    n_hit     = 1'b1;
                    n_hit_idx = r_rd_idx;
                    n_state   = ST_DONE;
                end else if (r_idx < r_cnt) begin
                    // issue the next read, compare it next cycle
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    n_idx    = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_idx   = '0;
                    n_out_found = 1'b0;
                    n_out_full  = 1'b0;
                    if (r_hit) begin
                        n_out_idx   = vdp_pkg::out_index(r_hit_idx);
                        n_out_found = 1'b1;
                    end else if (r_kind != vdp_pkg::KIND_LOOKUP) begin
                        if (r_cnt < vdp_pkg::CNT_W'(vdp_pkg::POOL_DEPTH)) begin
                            // append the new vertex at the end of the pool
                            mem_req.we   = 1'b1;
                            mem_req.addr = r_cnt[vdp_pkg::IDX_W-1:0];
                            n_out_idx    = vdp_pkg::out_index(r_cnt);
                            n_cnt        = r_cnt + 1'b1;
                        end else begin
                            n_out_full = 1'b1;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_hit_idx   <= n_hit_idx;
        r_out_idx   <= n_out_idx;
        r_out_found <= n_out_found;
        r_out_full  <= n_out_full;
        if (o_s_tready && i_s_tvalid) begin
            r_kind <= i_s_tuser;
            r_vtx  <= {vdp_pkg::norm_coord(i_s_tdata[47:32]),
                       vdp_pkg::norm_coord(i_s_tdata[31:16]),
                       vdp_pkg::norm_coord(i_s_tdata[15:0])};
        end
    end

endmodule
`default_nettype wire

// ===== design/vdp_checker.sv =====
`default_nettype none
module vdp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [47:0] i_s_tdata,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    // a dropped insert is never also a hit
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("pool_full and found both set");

    // a dropped insert reports index zero
    a_full_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata == 8'd0))
        else $error("pool_full with nonzero index");

    // one item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item taken while previous item still scanning");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind vertex_dedup_pool vdp_checker u_vdp_checker (.*);
`default_nettype wire

// ===== verif/vertex_dedup_pool_tb.sv =====
`timescale 1ns / 100ps

module vertex_dedup_pool_tb;
    import vdp_pkg::*;

    // a full scan plus handshake slack, taken several times over
    localparam int SCAN_CYCLES = POOL_DEPTH + 8;
    localparam int STALL_LIMIT = 8 * SCAN_CYCLES;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 found;
        logic                 full;
    } t_dedup_result;

    typedef struct packed {
        logic                 kind;
        logic [15:0]          x;
        logic [15:0]          y;
        logic [15:0]          z;
        logic                 typed;   // expected result written in the row
        logic [OUT_IDX_W-1:0] index;
        logic                 found;
        logic                 full;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;

    vertex_dedup_pool dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // shadow copy of the pool: normalized keys plus the raw items that made them
    t_vertex       pool_keys [POOL_DEPTH];
    logic [47:0]   pool_raw [POOL_DEPTH];
    int unsigned   pool_used;

    t_dedup_result pending_results [$];
    int            error_total;
    int            idle_cycles;
    int            sender_idle_pct;
    int            receiver_stall_pct;

    // hand-checked opening sequence, starting from an empty pool
    t_stim_row directed_rows [0:18] = '{
        '{KIND_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b1, 1'b0},
        '{KIND_INSERT, 16'h8000, 16'h8000, 16'h8000, 1'b1, 8'd1, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 8'd2, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h7fff, 16'h8000, 16'h0000, 1'b0, 8'd0, 1'b0, 1'b0},
        '{KIND_INSERT, 16'hffff, 16'hffff, 16'hffff, 1'b0, 8'd0, 1'b0, 1'b0},
        '{KIND_LOOKUP, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 8'd2, 1'b1, 1'b0},
        '{KIND_LOOKUP, 16'h8000, 16'h8000, 16'h8001, 1'b1, 8'd0, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h0000, 16'h0000, 16'h0001, 1'b1, 8'd5, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h0000, 16'h0001, 16'h0000, 1'b1, 8'd6, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h0001, 16'h0000, 16'h0000, 1'b1, 8'd7, 1'b0, 1'b0},
        '{KIND_LOOKUP, 16'h0001, 16'h0000, 16'h0000, 1'b1, 8'd7, 1'b1, 1'b0},
        '{KIND_INSERT, 16'hffff, 16'hffff, 16'hffff, 1'b1, 8'd4, 1'b1, 1'b0},
        '{KIND_LOOKUP, 16'hffff, 16'hffff, 16'hfffe, 1'b1, 8'd0, 1'b0, 1'b0},
        '{KIND_INSERT, 16'h8000, 16'h7fff, 16'hffff, 1'b0, 8'd0, 1'b0, 1'b0},
        '{KIND_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b1, 1'b0},
        '{KIND_INSERT, 16'h5555, 16'haaaa, 16'h00ff, 1'b0, 8'd0, 1'b0, 1'b0},
        '{KIND_LOOKUP, 16'h5555, 16'haaaa, 16'h00ff, 1'b0, 8'd0, 1'b0, 1'b0}
    };

    // sign-extend a raw coordinate and keep the stored width
    function automatic t_coord fold_coord(input logic [15:0] raw);
        logic [31:0] wide;
        wide = {{16{raw[15]}}, raw};
        return wide[COORD_BITS-1:0];
    endfunction

    // search the shadow pool, append on an insert miss, return the answer
    function automatic t_dedup_result dedup_vertex(input logic kind, input logic [47:0] raw);
        t_vertex       key;
        t_dedup_result res;
        int            hit;
        key = {fold_coord(raw[47:32]), fold_coord(raw[31:16]), fold_coord(raw[15:0])};
        res = '0;
        hit = -1;
        for (int i = 0; i < pool_used; i++) begin
            if (hit < 0 && pool_keys[i] == key) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            res.index = hit[OUT_IDX_W-1:0];
            res.found = 1'b1;
        end else if (kind == KIND_INSERT) begin
            if (pool_used < POOL_DEPTH) begin
                pool_keys[pool_used] = key;
                pool_raw[pool_used]  = raw;
                res.index = pool_used[OUT_IDX_W-1:0];
                pool_used++;
            end else begin
                // pool full, vertex dropped
                res.full = 1'b1;
            end
        end
        return res;
    endfunction

    // coordinates lean toward the range ends, zero and all ones now and then
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(15))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (error_total < MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
        error_total++;
    endtask

    // drive one item; entered and left at a falling edge
    task automatic send_vertex(input logic kind, input logic [47:0] raw,
                               input logic typed, input t_dedup_result typed_res);
        t_dedup_result res;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= raw;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        res = dedup_vertex(kind, raw);
        if (typed) begin
            res = typed_res;
        end
        pending_results = {pending_results, res};
        @(negedge i_clk);
    endtask

    // hold off the sender until every answer is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // receiver ready, re-rolled every cycle
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_dedup_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected item: index %0d found %0b full %0b",
                                       o_m_tdata, o_m_tuser[0], o_m_tuser[1]));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.index || o_m_tuser[0] !== want.found ||
                    o_m_tuser[1] !== want.full) begin
                    report_error($sformatf(
                        "mismatch: index %0d/%0d found %0b/%0b full %0b/%0b (exp/got)",
                        want.index, o_m_tdata, want.found, o_m_tuser[0],
                        want.full, o_m_tuser[1]));
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("vertex_dedup_pool_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_dedup_result typed_res;
        logic [47:0]   raw;
        logic          kind;
        int            pick;
        int            phase_idle [4];
        int            phase_stall [4];

        phase_idle  = '{0, 60, 0, 22};
        phase_stall = '{0, 0, 60, 22};

        i_rst_n            = 1'b0;
        i_s_tvalid         = 1'b0;
        i_s_tdata          = '0;
        i_s_tuser          = KIND_INSERT;
        i_m_tready         = 1'b0;
        pool_used          = 0;
        error_total        = 0;
        idle_cycles        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening: empty pool, corners, duplicates, near misses
        foreach (directed_rows[r]) begin
            typed_res = '{directed_rows[r].index, directed_rows[r].found, directed_rows[r].full};
            send_vertex(directed_rows[r].kind,
                        {directed_rows[r].z, directed_rows[r].y, directed_rows[r].x},
                        directed_rows[r].typed, typed_res);
        end
        drain_results();

        // random phases; new inserts dominate so the pool fills and overflows
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = phase_idle[ph];
            receiver_stall_pct = phase_stall[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                kind = 1'($urandom);
                if (pick < 55 || pool_used == 0) begin
                    kind = KIND_INSERT;
                    raw  = {pick_coord(), pick_coord(), pick_coord()};
                end else if (pick < 75) begin
                    // exact repeat of a stored vertex
                    raw = pool_raw[$urandom_range(pool_used - 1)];
                end else if (pick < 88) begin
                    // one bit away from a stored vertex
                    raw = pool_raw[$urandom_range(pool_used - 1)] ^ (48'd1 << $urandom_range(47));
                end else begin
                    kind = KIND_LOOKUP;
                    raw  = {pick_coord(), pick_coord(), pick_coord()};
                end
                send_vertex(kind, raw, 1'b0, '0);
            end
            drain_results();
        end

        // let a last scan run out in case something stray is still coming
        repeat (SCAN_CYCLES) @(posedge i_clk);

        if (error_total == 0 && pending_results.size() == 0) begin
            $display("vertex_dedup_pool_tb: PASS");
        end else begin
            $display("vertex_dedup_pool_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== vertex_dedup_pool.f =====
design/vdp_pkg.sv
design/vdp_store.sv
design/vertex_dedup_pool.sv
design/vdp_checker.sv
verif/vertex_dedup_pool_tb.sv
